/* src/rfsa_pkg.sv */
`default_nettype none

package rfsa_pkg;

  // Fixed field widths of the event and result channels
  localparam int ROOM_W = 11;
  localparam int ID_W   = 10;

  // Default sizes of the free-room stack and the customer table
  localparam int MAX_ROOMS_DEF     = 1024;
  localparam int MAX_CUSTOMERS_DEF = 1024;

  // Room count loaded at reset
  localparam int RESET_ROOMS = 1024;

endpackage

`default_nettype wire

/* src/room_free_stack_allocator_core.sv */
`default_nettype none

// Room allocator with a LIFO free-room stack. An event is taken when start is
// high and busy is low. The cycle of acceptance launches the memory reads
// (stack top or the customer's recorded room); the next cycle, with busy
// high, does the read-modify-write of the stack and the customer table. The
// result appears on out_* with out_valid for one cycle after that, and a new
// event may be started in that same cycle; while one event executes, no new
// event is taken, since the memory reads are registered. There is no result
// backpressure: out_valid pulses once per event and the receiver must take
// it. Writing cfg_wdata with cfg_we reloads the room count (capped at
// MAX_ROOMS) and empties the free stack; write it only while no event is in
// flight. An arrival with no room left returns room 0 with out_alloc_error
// set.
module room_free_stack_allocator_core #(
  parameter int MAX_ROOMS     = rfsa_pkg::MAX_ROOMS_DEF,
  parameter int MAX_CUSTOMERS = rfsa_pkg::MAX_CUSTOMERS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  output logic                             busy,
  input  wire logic                        in_req_type,
  input  wire logic [rfsa_pkg::ID_W-1:0]   in_customer_id,
  output logic                             out_valid,
  output logic [rfsa_pkg::ROOM_W-1:0]      out_room_number,
  output logic                             out_alloc_error,
  input  wire logic                        cfg_we,
  input  wire logic [rfsa_pkg::ROOM_W-1:0] cfg_wdata
);

  import rfsa_pkg::*;

  localparam int CNT_W = $clog2(MAX_ROOMS + 1);
  localparam int SAW   = $clog2(MAX_ROOMS);
  localparam int CAW   = $clog2(MAX_CUSTOMERS);
  localparam logic [ROOM_W-1:0] FRESH_RST =
    (RESET_ROOMS > MAX_ROOMS) ? ROOM_W'(MAX_ROOMS) : ROOM_W'(RESET_ROOMS);

  typedef enum logic {S_IDLE, S_EXEC} state_t;

  state_t            state_r;
  logic              req_r;
  logic [CAW-1:0]    cidx_r;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt, cnt_dec;
  logic [ROOM_W-1:0] fresh_r, fresh_nxt, fresh_cap;
  logic              out_valid_r;
  logic [ROOM_W-1:0] room_r, room_nxt;
  logic              err_r, err_nxt;

  logic              accept;
  logic [31:0]       cust_rem;
  logic [CAW-1:0]    cust_idx;

  logic              stk_we, tbl_we;
  logic [SAW-1:0]    stk_raddr;
  logic [ROOM_W-1:0] stk_rdata, tbl_rdata;

  assign accept = start && (state_r == S_IDLE);
  assign busy   = (state_r == S_EXEC);

  // Customer index wraps modulo the table depth (shift-and-subtract reduce)
  always_comb begin
    cust_rem = 32'(in_customer_id);
    for (int k = ID_W - 1; k >= 0; k--) begin
      if (cust_rem >= (32'(MAX_CUSTOMERS) << k)) begin
        cust_rem = cust_rem - (32'(MAX_CUSTOMERS) << k);
      end
    end
  end
  assign cust_idx = cust_rem[CAW-1:0];

  // Stack top address for a pop
  assign cnt_dec   = cnt_r - CNT_W'(1);
  assign stk_raddr = cnt_dec[SAW-1:0];

  // Room count on a config write, capped at the stack depth
  always_comb begin
    if (32'(cfg_wdata) > 32'(MAX_ROOMS)) begin
      fresh_cap = ROOM_W'(MAX_ROOMS);
    end else begin
      fresh_cap = cfg_wdata;
    end
  end

  // Read-modify-write of stack and customer table
  always_comb begin
    room_nxt  = '0;
    err_nxt   = 1'b0;
    cnt_nxt   = cnt_r;
    fresh_nxt = fresh_r;
    stk_we    = 1'b0;
    tbl_we    = 1'b0;
    if (state_r == S_EXEC) begin
      if (req_r) begin
        tbl_we = 1'b1;
        if (cnt_r != '0) begin
          room_nxt = stk_rdata;
          cnt_nxt  = cnt_dec;
        end else if (fresh_r != '0) begin
          room_nxt  = fresh_r;
          fresh_nxt = fresh_r - ROOM_W'(1);
        end else begin
          err_nxt = 1'b1;
        end
      end else begin
        room_nxt = tbl_rdata;
        if ((tbl_rdata != '0) && (32'(cnt_r) < 32'(MAX_ROOMS))) begin
          stk_we  = 1'b1;
          cnt_nxt = cnt_r + CNT_W'(1);
        end
      end
    end
  end

  // State, counters and registered result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      fresh_r     <= FRESH_RST;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= (state_r == S_EXEC);
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            state_r <= S_EXEC;
          end
        end
        S_EXEC: begin
          state_r <= S_IDLE;
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
      if (cfg_we) begin
        fresh_r <= fresh_cap;
        cnt_r   <= '0;
      end else begin
        fresh_r <= fresh_nxt;
        cnt_r   <= cnt_nxt;
      end
    end
    if (accept) begin
      req_r  <= in_req_type;
      cidx_r <= cust_idx;
    end
    room_r <= room_nxt;
    err_r  <= err_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_room_number = room_r;
  assign out_alloc_error = err_r;

  // Free-room stack
  rfsa_ram #(
    .WIDTH (ROOM_W),
    .DEPTH (MAX_ROOMS)
  ) u_stack (
    .clk   (clk),
    .we    (stk_we),
    .waddr (cnt_r[SAW-1:0]),
    .wdata (room_nxt),
    .raddr (stk_raddr),
    .rdata (stk_rdata)
  );

  // Room recorded per customer
  rfsa_ram #(
    .WIDTH (ROOM_W),
    .DEPTH (MAX_CUSTOMERS)
  ) u_table (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (cidx_r),
    .wdata (room_nxt),
    .raddr (cust_idx),
    .rdata (tbl_rdata)
  );

  // Each accepted event leaves execution in the cycle after it entered it
  a_exec_once: assert property (@(posedge clk) disable iff (!rst_n)
    busy |=> !busy) else $error("execution cycle did not end");

  // A result strobe follows the execution of every accepted event
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> ##1 out_valid) else $error("result strobe missing");

  // An allocation failure always reports room 0
  a_err_room0: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_alloc_error) |-> (out_room_number == '0))
    else $error("error result with nonzero room");

  // Free stack never overfills
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(cnt_r) <= 32'(MAX_ROOMS)) else $error("free stack overflow");

endmodule

`default_nettype wire

/* src/rfsa_ram.sv */
`default_nettype none

// Simple dual-port RAM: one write port, one read port, registered read data.
module rfsa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire
